/* rtl/disparity_to_point_reprojector_unit_macros.svh */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTOR_UNIT_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTOR_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dpr assertion failed");

// Condition that must never be seen outside reset.
`define DPR_NEVER(lbl, cond) \
    `DPR_ASSERT(lbl, !(cond))

`endif

/* rtl/dpr_pkg.sv */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector package
// Shared constants, payload types and a helper function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

    localparam int COORD_BITS      = 12;
    localparam int CFG_REGS        = 8;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int COEF_W          = 32;
    localparam int MIN_DISP        = 2;
    localparam int PROD_W          = COEF_W + COORD_BITS + 1;
    localparam int SUM_W           = COORD_BITS + 34;
    localparam int MAG_W           = SUM_W;
    localparam int REM_W           = MAG_W + 1;
    localparam int Q_W             = 32;
    localparam int FRAC_BITS       = 16;
    localparam int DIV_STAGES      = 16;
    localparam int STEPS_PER_STAGE = Q_W / DIV_STAGES;
    localparam int LANES           = 3;

    localparam logic [Q_W-1:0] Q_POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row_index;
        logic [7:0]  disparity;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        packed_rgb;
        logic               overflow;
    } t_point;

    typedef logic [CFG_DATA_W-1:0]      t_cfg_word;
    typedef t_cfg_word [CFG_REGS-1:0]   t_matrix;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef t_sum [3:0]                 t_sums;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   feed;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             num_neg;
        logic             num_nz;
        logic             sat;
    } t_lane;

    typedef struct packed {
        t_lane [LANES-1:0] lanes;
        logic [MAG_W-1:0]  den;
        logic              den_zero;
        logic [23:0]       rgb;
    } t_div_word;

    function automatic logic signed [COEF_W-1:0] coef_half(input t_cfg_word w,
                                                          input logic hi);
        return hi ? $signed(w[2*COEF_W-1:COEF_W]) : $signed(w[COEF_W-1:0]);
    endfunction

endpackage

`default_nettype wire

/* rtl/dpr_matrix.sv */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector matrix product
// Registers the pixel, forms the twelve coefficient products and sums rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpr_matrix import dpr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_pixel  i_pixel,
    input  wire t_matrix i_matrix,
    output logic         o_valid,
    output t_sums        o_sums,
    output logic [23:0]  o_rgb
);

    logic                  r_a_valid;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [7:0]            r_disp;
    logic [23:0]           r_a_rgb;

    logic                          r_b_valid;
    logic signed [PROD_W-1:0]      r_prod [4][3];
    logic signed [COEF_W-1:0]      r_const [4];
    logic [23:0]                   r_b_rgb;

    logic signed [PROD_W-1:0]      n_prod [4][3];
    logic signed [COEF_W-1:0]      n_const [4];
    t_sums                         n_sums;
    t_sums                         r_sums;
    logic                          r_c_valid;
    logic [23:0]                   r_c_rgb;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_prod[k][0] = coef_half(i_matrix[2*k], 1'b0) * $signed({1'b0, r_col});
            n_prod[k][1] = coef_half(i_matrix[2*k], 1'b1) * $signed({1'b0, r_row});
            n_prod[k][2] = coef_half(i_matrix[2*k+1], 1'b0) * $signed({1'b0, r_disp});
            n_const[k]   = coef_half(i_matrix[2*k+1], 1'b1);
            n_sums[k]    = SUM_W'(r_prod[k][0]) + SUM_W'(r_prod[k][1])
                         + SUM_W'(r_prod[k][2]) + SUM_W'(r_const[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        r_col   <= i_pixel.column[COORD_BITS-1:0];
        r_row   <= i_pixel.row_index[COORD_BITS-1:0];
        r_disp  <= i_pixel.disparity;
        r_a_rgb <= {i_pixel.red, i_pixel.green, i_pixel.blue};
        r_prod  <= n_prod;
        r_const <= n_const;
        r_b_rgb <= r_a_rgb;
        r_sums  <= n_sums;
        r_c_rgb <= r_b_rgb;
    end

    assign o_valid = r_c_valid;
    assign o_sums  = r_sums;
    assign o_rgb   = r_c_rgb;

endmodule

`default_nettype wire

/* rtl/dpr_div_step.sv */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector divider stage
// Two restoring division steps for each of the three coordinate lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpr_div_step import dpr_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_div_word i_word,
    output logic           o_valid,
    output t_div_word      o_word
);

    t_div_word        n_word;
    t_div_word        r_word;
    logic             r_valid;
    logic [REM_W-1:0] rem;
    logic             qbit;

    always_comb begin
        n_word = i_word;
        rem    = '0;
        qbit   = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                rem  = {n_word.lanes[l].rem[REM_W-2:0], n_word.lanes[l].feed[Q_W-1]};
                qbit = (rem >= {1'b0, n_word.den});
                if (qbit) begin
                    rem = rem - {1'b0, n_word.den};
                end
                n_word.lanes[l].rem  = rem;
                n_word.lanes[l].feed = {n_word.lanes[l].feed[Q_W-2:0], 1'b0};
                n_word.lanes[l].quo  = {n_word.lanes[l].quo[Q_W-2:0], qbit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

/* rtl/disparity_to_point_reprojector_unit.sv */
// Pixels pass the matrix, magnitude, set-up, divider and output registers in turn.
// Throughput: one pixel per cycle; busy stays low and start is taken every cycle.
// Most of the depth comes from the 16-stage divider, two quotient bits per stage.
// Pixels with disparity below two leave no result and no strobe.
// Synchronous active-low reset clears the matrix to zero and empties the pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector
// Projects disparity pixels through a 4x4 Q16.16 matrix into 3-D points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_point_reprojector_unit import dpr_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_pixel                i_pixel,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output t_point                     o_point
);

    t_matrix     r_matrix;
    logic        m_valid;
    t_sums       m_sums;
    logic [23:0] m_rgb;

    logic        r_abs_valid;
    t_div_word   n_abs;
    t_div_word   r_abs;
    logic        r_prep_valid;
    t_div_word   n_prep;
    t_div_word   r_prep;

    logic        d_valid [DIV_STAGES+1];
    t_div_word   d_word  [DIV_STAGES+1];

    t_point      n_point;
    t_point      r_point;
    logic        r_out_valid;

    logic [MAG_W-1:0]       num;
    logic [Q_W:0]           limit;
    logic [LANES-1:0][31:0] coord;
    logic [LANES-1:0]       lane_ovf;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= '0;
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(CFG_REGS))) begin
            r_matrix[i_cfg_idx[$clog2(CFG_REGS)-1:0]] <= i_cfg_data;
        end
    end

    dpr_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy && (i_pixel.disparity >= 8'(MIN_DISP))),
        .i_pixel  (i_pixel),
        .i_matrix (r_matrix),
        .o_valid  (m_valid),
        .o_sums   (m_sums),
        .o_rgb    (m_rgb)
    );

    // The numerator magnitude rides in the remainder field until the set-up stage.
    always_comb begin
        n_abs          = '0;
        n_abs.den      = m_sums[3][SUM_W-1] ? MAG_W'(-m_sums[3]) : MAG_W'(m_sums[3]);
        n_abs.den_zero = (m_sums[3] == '0);
        n_abs.rgb      = m_rgb;
        for (int l = 0; l < LANES; l++) begin
            n_abs.lanes[l].rem     = m_sums[l][SUM_W-1] ? REM_W'(MAG_W'(-m_sums[l]))
                                                        : REM_W'(MAG_W'(m_sums[l]));
            n_abs.lanes[l].num_neg = m_sums[l][SUM_W-1];
            n_abs.lanes[l].num_nz  = (m_sums[l] != '0);
            n_abs.lanes[l].neg     = m_sums[l][SUM_W-1] ^ m_sums[3][SUM_W-1];
        end
    end

    always_comb begin
        n_prep = r_abs;
        num    = '0;
        for (int l = 0; l < LANES; l++) begin
            num                   = r_abs.lanes[l].rem[MAG_W-1:0];
            n_prep.lanes[l].sat   = ({{FRAC_BITS{1'b0}}, num} >= {r_abs.den, {FRAC_BITS{1'b0}}});
            n_prep.lanes[l].rem   = REM_W'(num >> FRAC_BITS);
            n_prep.lanes[l].feed  = {num[FRAC_BITS-1:0], {(Q_W-FRAC_BITS){1'b0}}};
            n_prep.lanes[l].quo   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_valid  <= 1'b0;
            r_prep_valid <= 1'b0;
        end else begin
            r_abs_valid  <= m_valid;
            r_prep_valid <= r_abs_valid;
        end
        r_abs  <= n_abs;
        r_prep <= n_prep;
    end

    assign d_valid[0] = r_prep_valid;
    assign d_word[0]  = r_prep;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        dpr_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d_valid[g]),
            .i_word  (d_word[g]),
            .o_valid (d_valid[g+1]),
            .o_word  (d_word[g+1])
        );
    end

    always_comb begin
        coord    = '0;
        lane_ovf = '0;
        limit    = '0;
        for (int l = 0; l < LANES; l++) begin
            limit = d_word[DIV_STAGES].lanes[l].neg ? {1'b0, Q_NEG_LIMIT}
                                                    : {1'b0, Q_POS_LIMIT};
            if (d_word[DIV_STAGES].den_zero) begin
                lane_ovf[l] = 1'b1;
                if (!d_word[DIV_STAGES].lanes[l].num_nz) begin
                    coord[l] = '0;
                end else if (d_word[DIV_STAGES].lanes[l].num_neg) begin
                    coord[l] = Q_NEG_LIMIT;
                end else begin
                    coord[l] = Q_POS_LIMIT;
                end
            end else if (d_word[DIV_STAGES].lanes[l].sat ||
                         ({1'b0, d_word[DIV_STAGES].lanes[l].quo} > limit)) begin
                lane_ovf[l] = 1'b1;
                coord[l]    = limit[Q_W-1:0];
            end else if (d_word[DIV_STAGES].lanes[l].neg) begin
                coord[l] = -d_word[DIV_STAGES].lanes[l].quo;
            end else begin
                coord[l] = d_word[DIV_STAGES].lanes[l].quo;
            end
        end
        n_point.point_x    = $signed(coord[0]);
        n_point.point_y    = $signed(coord[1]);
        n_point.point_z    = $signed(coord[2]);
        n_point.packed_rgb = d_word[DIV_STAGES].rgb;
        n_point.overflow   = |lane_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= d_valid[DIV_STAGES];
        end
        r_point <= n_point;
    end

    assign o_valid = r_out_valid;
    assign o_point = r_point;

endmodule

`default_nettype wire

/* rtl/dpr_checker.sv */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector checker
// Port-level checks on result timing, colour pass-through and readiness.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disparity_to_point_reprojector_unit_macros.svh"

module dpr_checker import dpr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    input  wire logic   busy,
    input  wire t_pixel i_pixel,
    input  wire logic   o_valid,
    input  wire t_point o_point
);

    logic        in_take;
    logic [23:0] in_rgb;

    assign in_take = start && !busy && (i_pixel.disparity >= 8'(MIN_DISP));
    assign in_rgb  = {i_pixel.red, i_pixel.green, i_pixel.blue};

    `DPR_ASSERT(a_strobe_has_source, o_valid |-> $past(in_take, 22))
    `DPR_ASSERT(a_colour_kept, o_valid |-> (o_point.packed_rgb == $past(in_rgb, 22)))
    `DPR_NEVER(a_never_busy, busy)

endmodule

bind disparity_to_point_reprojector_unit dpr_checker u_dpr_checker (.*);

`default_nettype wire

/* tb/sv/disparity_to_point_reprojector_unit_tb.sv */
// ---------------------------------------------------------------------------
// Disparity-to-point reprojector testbench
// Streams pixels through the unit under several matrix loads. An in-bench
// model forms the four exact row sums and the saturating Q16.16 quotients,
// and every result word is checked field by field against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_point_reprojector_unit_tb;
    import dpr_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_A, REG_ROW0_B, REG_ROW1_A, REG_ROW1_B,
        REG_ROW2_A, REG_ROW2_B, REG_ROW3_A, REG_ROW3_B
    } t_reg_idx;

    localparam int DRAIN_CYCLES = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_pixel                i_pixel = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    t_point                o_point;

    t_cfg_word matrix_model [CFG_REGS];
    t_point    expected_points [$];
    int        mismatches = 0;
    int        points_checked = 0;
    int        pixels_sent = 0;
    int        loads_done = 0;

    disparity_to_point_reprojector_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel(i_pixel), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_point(o_point)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic longint coef(input t_cfg_word w, input bit hi);
        return hi ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    function automatic longint row_sum(input int k, input longint col, input longint row,
                                       input longint disp);
        return coef(matrix_model[2*k], 0) * col + coef(matrix_model[2*k], 1) * row +
               coef(matrix_model[2*k+1], 0) * disp + coef(matrix_model[2*k+1], 1);
    endfunction

    function automatic logic [31:0] q16_ratio(input longint num, input longint den,
                                              inout bit ovf);
        bit neg;
        longint unsigned n, d, qi, r, frac, q, limit;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (d == 0) begin
            ovf = 1'b1;
            if (num > 0) return Q_POS_LIMIT;
            if (num < 0) return Q_NEG_LIMIT;
            return '0;
        end
        limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        qi = n / d;
        r = n % d;
        if (qi > 64'hFFFF) begin
            ovf = 1'b1;
            return limit[31:0];
        end
        frac = (r << FRAC_BITS) / d;
        q = (qi << FRAC_BITS) | frac;
        if (q > limit) begin
            ovf = 1'b1;
            return limit[31:0];
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic bit project_pixel(input t_pixel p, output t_point pt);
        longint col, row, disp, den;
        bit ovf;
        col = p.column[COORD_BITS-1:0];
        row = p.row_index[COORD_BITS-1:0];
        disp = p.disparity;
        ovf = 1'b0;
        pt = '0;
        if (disp < MIN_DISP) return 1'b0;
        den = row_sum(3, col, row, disp);
        pt.point_x = q16_ratio(row_sum(0, col, row, disp), den, ovf);
        pt.point_y = q16_ratio(row_sum(1, col, row, disp), den, ovf);
        pt.point_z = q16_ratio(row_sum(2, col, row, disp), den, ovf);
        pt.packed_rgb = {p.red, p.green, p.blue};
        pt.overflow = ovf;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                t_point e;
                e = expected_points.pop_front();
                points_checked++;
                if (o_point.point_x !== e.point_x)
                    report_mismatch($sformatf("x %h, expected %h", o_point.point_x, e.point_x));
                if (o_point.point_y !== e.point_y)
                    report_mismatch($sformatf("y %h, expected %h", o_point.point_y, e.point_y));
                if (o_point.point_z !== e.point_z)
                    report_mismatch($sformatf("z %h, expected %h", o_point.point_z, e.point_z));
                if (o_point.packed_rgb !== e.packed_rgb)
                    report_mismatch($sformatf("rgb %h, expected %h",
                                              o_point.packed_rgb, e.packed_rgb));
                if (o_point.overflow !== e.overflow)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              o_point.overflow, e.overflow));
            end
        end
    end

    task automatic drain_points();
        start <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_matrix(input t_cfg_word m [CFG_REGS]);
        drain_points();
        for (int i = 0; i < CFG_REGS; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_reg_idx'(i);
            i_cfg_data <= m[i];
            @(posedge i_clk);
            matrix_model[i] = m[i];
        end
        i_cfg_we <= 1'b0;
        loads_done++;
    endtask

    task automatic send_pixel(input t_pixel p, input int gap);
        t_point pt;
        i_pixel <= p;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pixels_sent++;
        if (project_pixel(p, pt)) expected_points = {expected_points, pt};
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_cfg_word pack_coefs(input logic [31:0] hi, input logic [31:0] lo);
        return {hi, lo};
    endfunction

    function automatic logic [31:0] wild_coef();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // A camera-like matrix: centred pixel coordinates over disparity, jittered so
    // every coefficient bit moves across loads; wild draws edge and random words.
    task automatic make_matrix(input bit wild, output t_cfg_word m [CFG_REGS]);
        logic [31:0] c [8];
        if (wild) begin
            foreach (c[i]) c[i] = wild_coef();
        end else begin
            c[0] = 32'h0001_0000 + $urandom_range(0, 4095) - 2048;
            c[1] = $urandom_range(0, 511) - 256;
            c[2] = $urandom_range(0, 255) - 128;
            c[3] = -($urandom_range(0, 4095) << 16);
            c[4] = $urandom_range(0, 511) - 256;
            c[5] = 32'h0001_0000 + $urandom_range(0, 4095) - 2048;
            c[6] = $urandom_range(0, 1023) - 512;
            c[7] = -($urandom_range(0, 4095) << 16);
            c[0] = ($urandom_range(0, 1)) ? c[0] : -c[0];
        end
        for (int i = 0; i < 4; i++) m[i] = pack_coefs(c[2*i+1], c[2*i]);
        m[4] = wild ? pack_coefs(wild_coef(), wild_coef())
                    : pack_coefs($urandom_range(0, 16'hFFFF), $urandom_range(0, 255));
        m[5] = wild ? pack_coefs(wild_coef(), wild_coef())
                    : pack_coefs($urandom_range(1, 32'h7FFF_FFFF), $urandom);
        m[6] = wild ? pack_coefs(wild_coef(), wild_coef())
                    : pack_coefs($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32);
        m[7] = wild ? pack_coefs(wild_coef(), wild_coef())
                    : pack_coefs($urandom_range(0, 255), $urandom_range(16'h0100, 16'h4000));
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        p = t_pixel'(($bits(t_pixel))'({$urandom, $urandom}));
        if ($urandom_range(0, 9) == 0) p.disparity = 8'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic test_reset_matrix();
        for (int i = 0; i < 6; i++) send_pixel(random_pixel(), $urandom_range(0, 9));
        send_pixel('{column: 12'd5, row_index: 12'd9, disparity: 8'd2,
                     red: 8'd1, green: 8'd2, blue: 8'd3}, 0);
    endtask

    task automatic test_directed();
        t_cfg_word m [CFG_REGS];
        // Constant x and y numerators at the edges of range over a unit divisor.
        m[REG_ROW0_A] = '0;
        m[REG_ROW0_B] = pack_coefs(32'h8000_0000, '0);
        m[REG_ROW1_A] = '0;
        m[REG_ROW1_B] = pack_coefs(32'h7FFF_FFFF, '0);
        m[REG_ROW2_A] = pack_coefs(32'h0001_0000, 32'hFFFF_0000);
        m[REG_ROW2_B] = pack_coefs('0, 32'h0000_8000);
        m[REG_ROW3_A] = '0;
        m[REG_ROW3_B] = pack_coefs(32'h0001_0000, '0);
        load_matrix(m);
        send_pixel('{12'd0, 12'd0, 8'd2, 8'd0, 8'd0, 8'd0}, 0);
        send_pixel('{12'hFFF, 12'hFFF, 8'd255, 8'hFF, 8'hFF, 8'hFF}, 0);
        send_pixel('{12'hFFF, 12'd0, 8'd1, 8'hAA, 8'h55, 8'hAA}, 0);
        send_pixel('{12'd0, 12'hFFF, 8'd0, 8'h55, 8'hAA, 8'h55}, 1);
        send_pixel('{12'd100, 12'd3000, 8'd3, 8'h12, 8'h34, 8'h56}, 0);
        // Divisor from disparity only, numerators that overflow and go negative.
        m[REG_ROW0_A] = pack_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        m[REG_ROW0_B] = '0;
        m[REG_ROW1_A] = pack_coefs(32'h8000_0000, 32'h8000_0000);
        m[REG_ROW1_B] = '0;
        m[REG_ROW2_A] = pack_coefs('0, 32'hFFFF_FFFF);
        m[REG_ROW2_B] = pack_coefs(32'h0000_0001, '0);
        m[REG_ROW3_A] = '0;
        m[REG_ROW3_B] = pack_coefs('0, 32'hFFFF_FFFF);
        load_matrix(m);
        send_pixel('{12'd0, 12'd0, 8'd2, 8'd9, 8'd8, 8'd7}, 0);
        send_pixel('{12'd1, 12'd0, 8'd255, 8'd1, 8'd1, 8'd1}, 0);
        send_pixel('{12'hFFF, 12'hFFF, 8'd128, 8'd2, 8'd2, 8'd2}, 2);
        send_pixel('{12'd7, 12'd0, 8'd1, 8'd3, 8'd3, 8'd3}, 0);
        // Divisor that vanishes for some pixels, with numerators of each sign.
        m[REG_ROW3_A] = pack_coefs('0, 32'h0001_0000);
        m[REG_ROW3_B] = pack_coefs(32'hFFF0_0000, '0);
        m[REG_ROW0_B] = pack_coefs(32'h0000_0100, '0);
        load_matrix(m);
        send_pixel('{12'd16, 12'd0, 8'd9, 8'd4, 8'd5, 8'd6}, 0);
        send_pixel('{12'd0, 12'd16, 8'd200, 8'd7, 8'd8, 8'd9}, 0);
        send_pixel('{12'd17, 12'd4, 8'd2, 8'd10, 8'd11, 8'd12}, 0);
        send_pixel('{12'd15, 12'd4, 8'd2, 8'd13, 8'd14, 8'd15}, 0);
    endtask

    task automatic test_random_stream(input int loads, input int per_load);
        t_cfg_word m [CFG_REGS];
        for (int l = 0; l < loads; l++) begin
            make_matrix(l % 3 == 2, m);
            load_matrix(m);
            for (int i = 0; i < per_load; i++) begin
                if (i == per_load / 2 && l % 2 == 0) drain_points();
                send_pixel(random_pixel(), (i % 100 < 30) ? 0 : $urandom_range(0, 9));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_matrix();
        test_directed();
        test_random_stream(12, 150);
        drain_points();
        if (expected_points.size() != 0) report_mismatch("result words never arrived");
        $display("Sent %0d pixels over %0d matrix loads; %0d point words checked.",
                 pixels_sent, loads_done, points_checked);
        $display("Covered low disparity, zero divisors, saturation and both signs.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* disparity_to_point_reprojector_unit.f */
+incdir+rtl
rtl/dpr_pkg.sv
rtl/dpr_matrix.sv
rtl/dpr_div_step.sv
rtl/disparity_to_point_reprojector_unit.sv
rtl/dpr_checker.sv
tb/sv/disparity_to_point_reprojector_unit_tb.sv
